// ----- sv/mtr_pkg.sv -----
// Shared constants, types and helpers for the modulated threshold RK4 step unit.
package mtr_pkg;

  localparam int SIG_TABLE_BITS = 10;
  localparam int SIG_DEPTH      = 1 << SIG_TABLE_BITS;
  localparam int SIG_SHIFT      = 25 - SIG_TABLE_BITS;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic [23:0] sig_table_t [SIG_DEPTH];

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [23:0] sig_entry(input int i);
    logic signed [63:0] u;
    logic [63:0] a;
    logic [63:0] w;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] s;
    u    = (64'(i) << SIG_SHIFT) - 64'(1 << 24);
    a    = (u < 0) ? 64'(-u) : 64'(u);
    w    = a << 5;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = udiv((term * w) >> 30, 64'(n));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = 64'(sum);
    for (int n = 0; n < 5; n++) begin
      e = (e * e) >> 30;
    end
    d   = (64'd1 << 30) + e;
    num = (u >= 0) ? (64'd1 << 30) : e;
    s   = udiv((num << 24) + (d >> 1), d);
    if (s > 64'hFFFFFF) begin
      s = 64'hFFFFFF;
    end
    return s[23:0];
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t t;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      t[i] = sig_entry(i);
    end
    return t;
  endfunction

endpackage

// ----- sv/mtr_mul.sv -----
// Shared signed multiplier with registered product.
module mtr_mul (
  input  logic                                 clk_i,
  input  logic signed [mtr_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [mtr_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [mtr_pkg::MUL_P_W-1:0]   p_o
);

  logic signed [mtr_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= mtr_pkg::MUL_P_W'(a_i) * mtr_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- sv/mtr_sig_rom.sv -----
// Logistic table ROM, Q0.24 entries, registered read.
module mtr_sig_rom (
  input  logic                                clk_i,
  input  logic [mtr_pkg::SIG_TABLE_BITS-1:0]  addr_i,
  output logic [23:0]                         data_o
);

  localparam mtr_pkg::sig_table_t SigTable = mtr_pkg::build_sig_table();

  logic [23:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SigTable[addr_i];
  end

  assign data_o = data_q;

endmodule

// ----- sv/modulated_threshold_rk4_step_unit.sv -----
// Top level: one RK4 step of the modulated threshold H/X model per voltage beat.
// Each voltage beat runs four slope evaluations and a final threshold pass on one
// shared 33x32 multiplier under a sequencer: each slope steps through TX, TH, TS, ZM,
// ZS, XD, GX, KH and KX, the divide by six through DH, DX and DY, and the final pass
// through TX, TH and TS; the unit then returns to idle before the next beat is taken.
// The result sits in an output register; final TS waits only while the last is untaken.
// Configuration writes are taken at any time and act at once; write only when idle.
module modulated_threshold_rk4_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] voltage
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // [31:0] threshold, [63:32] h_value, [95:64] x_value
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TX   = 4'd1;
  localparam logic [3:0] ST_TH   = 4'd2;
  localparam logic [3:0] ST_TS   = 4'd3;
  localparam logic [3:0] ST_ZM   = 4'd4;
  localparam logic [3:0] ST_ZS   = 4'd5;
  localparam logic [3:0] ST_XD   = 4'd6;
  localparam logic [3:0] ST_GX   = 4'd7;
  localparam logic [3:0] ST_KH   = 4'd8;
  localparam logic [3:0] ST_KX   = 4'd9;
  localparam logic [3:0] ST_DH   = 4'd10;
  localparam logic [3:0] ST_DX   = 4'd11;
  localparam logic [3:0] ST_DY   = 4'd12;

  localparam logic [3:0] REG_OFFSET = 4'd0;
  localparam logic [3:0] REG_XCOEF  = 4'd1;
  localparam logic [3:0] REG_HCOEF  = 4'd2;
  localparam logic [3:0] REG_ISIG   = 4'd3;
  localparam logic [3:0] REG_XDRIVE = 4'd4;
  localparam logic [3:0] REG_RATEH  = 4'd5;
  localparam logic [3:0] REG_RATEX  = 4'd6;
  localparam logic [3:0] REG_INIT   = 4'd7;

  localparam logic [2:0] STAGE_FINAL = 3'd4;

  localparam int PW = mtr_pkg::MUL_P_W;
  localparam int TB = mtr_pkg::SIG_TABLE_BITS;

  logic [3:0] state_q, state_d;
  logic [2:0] stage_q;

  logic signed [31:0] theta_offset_q, theta_x_coeff_q, theta_h_coeff_q;
  logic [30:0] inv_sigma_q, x_drive_q, rate_h_q, rate_x_q;

  logic signed [31:0] h_q, x_q, th_q, tx_q, v_q, theta_q, gx_q, kh_q;
  logic signed [47:0] acc_q;
  logic signed [34:0] sh_q, sx_q;
  logic zlo_q, zhi_q;

  logic        out_valid_q;
  logic [95:0] out_data_q;

  logic signed [mtr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mtr_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               mul_p;
  logic [TB-1:0] rom_addr;
  logic [23:0]   rom_data;

  logic signed [47:0] p_fl20;
  logic signed [31:0] theta_new, gh, gx_new, k_new, trial_h, trial_x;
  logic signed [32:0] diff;
  logic [24:0]        sig;
  logic               two_w, half_k;
  logic signed [34:0] abs_h, abs_x, sum_sel, abs_sel, r_full, delta;
  logic signed [31:0] base_sel, div_new;
  logic [32:0]        q_est, q_fix;
  logic [1:0]         corr;
  logic               out_load, accept;

  mtr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mtr_sig_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign p_fl20    = 48'(mul_p >>> 20);
  assign theta_new = mtr_pkg::sat32(acc_q + p_fl20);
  assign diff      = 33'(v_q) - 33'(theta_q);
  assign rom_addr  = {~mul_p[44], mul_p[43:20+mtr_pkg::SIG_SHIFT]};
  assign sig       = zlo_q ? 25'd0 : (zhi_q ? 25'h1000000 : {1'b0, rom_data});
  assign gh        = mtr_pkg::sat32(48'(tx_q) + (48'(tx_q) <<< 1) - 48'(th_q));
  assign gx_new    = mtr_pkg::sat32(48'($signed({1'b0, mul_p[54:24]})) - 48'(tx_q));
  assign k_new     = mtr_pkg::sat32(p_fl20);
  assign two_w     = (stage_q == 3'd1) || (stage_q == 3'd2);
  assign half_k    = (stage_q != 3'd2);
  assign trial_h   = mtr_pkg::sat32(48'(h_q) + (half_k ? 48'(kh_q >>> 1) : 48'(kh_q)));
  assign trial_x   = mtr_pkg::sat32(48'(x_q) + (half_k ? 48'(k_new >>> 1) : 48'(k_new)));

  // divide by six: reciprocal estimate then small correction
  assign abs_h    = sh_q[34] ? -sh_q : sh_q;
  assign abs_x    = sx_q[34] ? -sx_q : sx_q;
  assign sum_sel  = (state_q == ST_DX) ? sh_q : sx_q;
  assign abs_sel  = (state_q == ST_DX) ? abs_h : abs_x;
  assign base_sel = (state_q == ST_DX) ? h_q : x_q;
  assign q_est    = mul_p[62:30];
  assign r_full   = abs_sel - ($signed(35'(q_est)) <<< 2) - ($signed(35'(q_est)) <<< 1);
  assign corr     = (r_full[4:0] >= 5'd12) ? 2'd2 : ((r_full[4:0] >= 5'd6) ? 2'd1 : 2'd0);
  assign q_fix    = q_est + 33'(corr);
  assign delta    = sum_sel[34] ? -$signed(35'(q_fix)) : $signed(35'(q_fix));
  assign div_new  = mtr_pkg::sat32(48'(base_sel) + 48'(delta));

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_TS) && (stage_q == STAGE_FINAL) &&
                    (!out_valid_q || m_axis_tready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_TX: begin
        mul_a = 33'(theta_x_coeff_q);
        mul_b = tx_q;
      end
      ST_TH: begin
        mul_a = 33'(theta_h_coeff_q);
        mul_b = th_q;
      end
      // keep the H term steady while the result waits
      ST_TS: begin
        mul_a = 33'(theta_h_coeff_q);
        mul_b = th_q;
      end
      ST_ZM: begin
        mul_a = diff;
        mul_b = $signed({1'b0, inv_sigma_q});
      end
      ST_XD: begin
        mul_a = $signed({2'b00, x_drive_q});
        mul_b = $signed({7'd0, sig});
      end
      ST_GX: begin
        mul_a = 33'(gh);
        mul_b = $signed({1'b0, rate_h_q});
      end
      ST_KH: begin
        mul_a = 33'(gx_q);
        mul_b = $signed({1'b0, rate_x_q});
      end
      ST_DH: begin
        mul_a = $signed({2'b00, abs_h[33:3]});
        mul_b = 32'sh55555555;
      end
      ST_DX: begin
        mul_a = $signed({2'b00, abs_x[33:3]});
        mul_b = 32'sh55555555;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_TX;
      ST_TX:   state_d = ST_TH;
      ST_TH:   state_d = ST_TS;
      ST_TS: begin
        if (stage_q != STAGE_FINAL) begin
          state_d = ST_ZM;
        end else if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_ZM:   state_d = ST_ZS;
      ST_ZS:   state_d = ST_XD;
      ST_XD:   state_d = ST_GX;
      ST_GX:   state_d = ST_KH;
      ST_KH:   state_d = ST_KX;
      ST_KX:   state_d = (stage_q == 3'd3) ? ST_DH : ST_TX;
      ST_DH:   state_d = ST_DX;
      ST_DX:   state_d = ST_DY;
      ST_DY:   state_d = ST_TX;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      stage_q         <= '0;
      out_valid_q     <= 1'b0;
      theta_offset_q  <= '0;
      theta_x_coeff_q <= '0;
      theta_h_coeff_q <= '0;
      inv_sigma_q     <= 31'd1048576;
      x_drive_q       <= '0;
      rate_h_q        <= '0;
      rate_x_q        <= '0;
      h_q             <= '0;
      x_q             <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_OFFSET: theta_offset_q  <= cfg_data_i[31:0];
          REG_XCOEF:  theta_x_coeff_q <= cfg_data_i[31:0];
          REG_HCOEF:  theta_h_coeff_q <= cfg_data_i[31:0];
          REG_ISIG:   inv_sigma_q     <= cfg_data_i[30:0];
          REG_XDRIVE: x_drive_q       <= cfg_data_i[30:0];
          REG_RATEH:  rate_h_q        <= cfg_data_i[30:0];
          REG_RATEX:  rate_x_q        <= cfg_data_i[30:0];
          REG_INIT: begin
            h_q <= cfg_data_i[31:0];
            x_q <= cfg_data_i[63:32];
          end
          default: ;
        endcase
      end
      if (accept) begin
        stage_q <= '0;
      end else if (state_q == ST_KX) begin
        stage_q <= stage_q + 3'd1;
      end
      if (state_q == ST_DX) h_q <= div_new;
      if (state_q == ST_DY) x_q <= div_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q  <= s_axis_tdata;
      th_q <= h_q;
      tx_q <= x_q;
      sh_q <= '0;
      sx_q <= '0;
    end
    unique case (state_q)
      ST_TH: acc_q <= 48'(theta_offset_q) - p_fl20;
      ST_TS: theta_q <= theta_new;
      ST_ZS: begin
        zlo_q <= (p_fl20 < -48'sd16777216);
        zhi_q <= (p_fl20 >= 48'sd16777216);
      end
      ST_GX: gx_q <= gx_new;
      ST_KH: kh_q <= k_new;
      ST_KX: begin
        sh_q <= sh_q + (two_w ? (35'(kh_q) <<< 1) : 35'(kh_q));
        sx_q <= sx_q + (two_w ? (35'(k_new) <<< 1) : 35'(k_new));
        th_q <= trial_h;
        tx_q <= trial_x;
      end
      ST_DY: begin
        th_q <= h_q;
        tx_q <= div_new;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= {x_q, h_q, theta_new};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule
